// File: rtl/core/mxzd_pkg.sv
// Shared constants for the Montgomery X:Z point doubling block.
package mxzd_pkg;
  // Configuration register indexes.
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_A24     = 1'b1;
  // Width of a single coordinate field on the ports.
  localparam int FIELD_BITS = 64;
endpackage

// File: rtl/core/montgomery_xz_point_double.sv
// Top level of the Montgomery X:Z point doubling pipeline.
//
// Usage: points (px, pz) enter on the s_* stream, doubled points (qx, qz)
// leave on the m_* stream, one result item per input item, in order.
// The user must write modulus and a24 on cfg_* only while idle (unchecked).
// The datapath is a chain of cells: WORD_BITS remainder cells reduce px, pz
// and a24 modulo n, then three rows of WORD_BITS double-and-add cells form
// (u^2, v^2), then (u^2*v^2, w*a24), then w*t. Every cell advances one
// step per cycle and one item is taken per cycle unless the output stalls.
// The whole chain advances together: when the output holds an item that the
// receiver does not take, the chain freezes and s_tready drops; bubbles in
// the chain never block input. A zero pz returns (px, 0); a zero modulus
// returns (0, 0). Synchronous reset empties the chain and sets modulus to 3
// and a24 to 0.
module montgomery_xz_point_double #(
  parameter int WORD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // px [63:0], pz [127:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // qx [63:0], qz [127:64]
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);
  import mxzd_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int RSB = W + 1;
  localparam int MSB = 3 * W + 1;

  function automatic logic [W-1:0] addm(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    return (a >= b) ? (a - b) : (a + (m - b));
  endfunction

  logic [FIELD_BITS-1:0] modulus, curve_a24;
  logic [W-1:0] nw;
  logic en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= FIELD_BITS'(3);
      curve_a24 <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODULUS) begin
        modulus <= cfg_data;
      end else if (cfg_index == REG_A24) begin
        curve_a24 <= cfg_data;
      end
    end
  end

  assign nw       = modulus[W-1:0];
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Reduction chain.
  logic           rv [0:W];
  logic [3*W-1:0] rdv[0:W];
  logic [3*W-1:0] rr [0:W];
  logic [RSB-1:0] rs [0:W];

  assign rv[0]  = s_tvalid;
  assign rdv[0] = {curve_a24[W-1:0], s_tdata[64 +: W], s_tdata[W-1:0]};
  assign rr[0]  = '0;
  assign rs[0]  = {(s_tdata[64 +: W] == '0), s_tdata[W-1:0]};

  for (genvar i = 0; i < W; i++) begin : g_red
    mxzd_red_cell #(.W(W), .SB(RSB)) u_cell (
      .clk, .rst, .en, .n(nw),
      .in_valid(rv[i]), .in_dv(rdv[i]), .in_r(rr[i]), .in_side(rs[i]),
      .out_valid(rv[i+1]), .out_dv(rdv[i+1]), .out_r(rr[i+1]), .out_side(rs[i+1])
    );
  end

  // Three multiplier rows; side bus is {inf, px, e1, e0}.
  logic         mv [0:2][0:W];
  logic [W-1:0] ma0[0:2][0:W];
  logic [W-1:0] mb0[0:2][0:W];
  logic [W-1:0] mr0[0:2][0:W];
  logic [W-1:0] ma1[0:2][0:W];
  logic [W-1:0] mb1[0:2][0:W];
  logic [W-1:0] mr1[0:2][0:W];
  logic [MSB-1:0] ms[0:2][0:W];

  logic [W-1:0] x0, z0, u0, v0, w1, t2;

  // Row one: u = x+z and v = x-z, each squared.
  always_comb begin
    x0 = rr[W][0 +: W];
    z0 = rr[W][W +: W];
    u0 = addm(x0, z0, nw);
    v0 = subm(x0, z0, nw);
  end
  assign mv[0][0]  = rv[W];
  assign ma0[0][0] = u0;
  assign mb0[0][0] = u0;
  assign ma1[0][0] = v0;
  assign mb1[0][0] = v0;
  assign ms[0][0]  = {rs[W], {W{1'b0}}, rr[W][2*W +: W]};

  // Row two: u^2*v^2 and w*a24, carrying w and v^2.
  assign w1        = subm(mr0[0][W], mr1[0][W], nw);
  assign mv[1][0]  = mv[0][W];
  assign ma0[1][0] = mr0[0][W];
  assign mb0[1][0] = mr1[0][W];
  assign ma1[1][0] = w1;
  assign mb1[1][0] = ms[0][W][W-1:0];
  assign ms[1][0]  = {ms[0][W][MSB-1 -: RSB], mr1[0][W], w1};

  // Row three: w*t with t = v^2 + w*a24, carrying qx.
  assign t2        = addm(mr1[1][W], ms[1][W][W +: W], nw);
  assign mv[2][0]  = mv[1][W];
  assign ma0[2][0] = '0;
  assign mb0[2][0] = '0;
  assign ma1[2][0] = ms[1][W][W-1:0];
  assign mb1[2][0] = t2;
  assign ms[2][0]  = {ms[1][W][MSB-1 -: RSB], mr0[1][W], {W{1'b0}}};

  for (genvar k = 0; k < 3; k++) begin : g_row
    assign mr0[k][0] = '0;
    assign mr1[k][0] = '0;
    for (genvar i = 0; i < W; i++) begin : g_mul
      mxzd_mul_cell #(.W(W), .SB(MSB)) u_cell (
        .clk, .rst, .en, .n(nw), .in_valid(mv[k][i]),
        .in_a0(ma0[k][i]), .in_b0(mb0[k][i]), .in_r0(mr0[k][i]),
        .in_a1(ma1[k][i]), .in_b1(mb1[k][i]), .in_r1(mr1[k][i]),
        .in_side(ms[k][i]), .out_valid(mv[k][i+1]),
        .out_a0(ma0[k][i+1]), .out_b0(mb0[k][i+1]), .out_r0(mr0[k][i+1]),
        .out_a1(ma1[k][i+1]), .out_b1(mb1[k][i+1]), .out_r1(mr1[k][i+1]),
        .out_side(ms[k][i+1])
      );
    end
  end

  // Output selection for the special cases.
  logic         f_inf;
  logic [W-1:0] f_px, f_qx, f_qz;

  always_comb begin
    f_inf = ms[2][W][MSB-1];
    f_px  = ms[2][W][2*W +: W];
    f_qx  = ms[2][W][W +: W];
    f_qz  = mr1[2][W];
    if (nw == '0) begin
      f_qx = '0;
      f_qz = '0;
    end else if (f_inf) begin
      f_qx = f_px;
      f_qz = '0;
    end
  end

  assign m_tvalid = mv[2][W];
  assign m_tdata  = {(FIELD_BITS)'(f_qz), (FIELD_BITS)'(f_qx)};

  a_ready : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid) else $error("input stalled with empty output");
  a_reset : assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid after reset");
  a_zero_mod : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && nw == '0) |-> (m_tdata == '0)) else $error("zero modulus result");
endmodule

// File: rtl/core/mxzd_red_cell.sv
// One restoring-remainder step for three lanes (x, z, a24) modulo n.
module mxzd_red_cell #(
  parameter int W  = 64,
  parameter int SB = 65
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [W-1:0]   n,
  input  logic           in_valid,
  input  logic [3*W-1:0] in_dv,
  input  logic [3*W-1:0] in_r,
  input  logic [SB-1:0]  in_side,
  output logic           out_valid,
  output logic [3*W-1:0] out_dv,
  output logic [3*W-1:0] out_r,
  output logic [SB-1:0]  out_side
);
  import mxzd_pkg::*;

  logic [3*W-1:0] r_next;
  logic [3*W-1:0] dv_next;

  // Shift in the next dividend bit and subtract n once when it fits.
  always_comb begin
    logic [W:0] t;
    r_next  = '0;
    dv_next = '0;
    for (int k = 0; k < 3; k++) begin
      t = {in_r[k*W +: W], in_dv[k*W + W - 1]};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      r_next[k*W +: W]  = t[W-1:0];
      dv_next[k*W +: W] = {in_dv[k*W +: W-1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r    <= r_next;
      out_dv   <= dv_next;
      out_side <= in_side;
    end
  end
endmodule

// File: rtl/core/mxzd_mul_cell.sv
// One double-and-add step of two modular products, most significant bit first.
module mxzd_mul_cell #(
  parameter int W  = 64,
  parameter int SB = 193
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [W-1:0]  n,
  input  logic          in_valid,
  input  logic [W-1:0]  in_a0,
  input  logic [W-1:0]  in_b0,
  input  logic [W-1:0]  in_r0,
  input  logic [W-1:0]  in_a1,
  input  logic [W-1:0]  in_b1,
  input  logic [W-1:0]  in_r1,
  input  logic [SB-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  out_a0,
  output logic [W-1:0]  out_b0,
  output logic [W-1:0]  out_r0,
  output logic [W-1:0]  out_a1,
  output logic [W-1:0]  out_b1,
  output logic [W-1:0]  out_r1,
  output logic [SB-1:0] out_side
);
  import mxzd_pkg::*;

  function automatic logic [W-1:0] addm(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  logic [W-1:0] d0, d1, r0_next, r1_next;

  // Double the partial result, then add a when the current bit of b is set.
  always_comb begin
    d0 = addm(in_r0, in_r0, n);
    d1 = addm(in_r1, in_r1, n);
    r0_next = in_b0[W-1] ? addm(d0, in_a0, n) : d0;
    r1_next = in_b1[W-1] ? addm(d1, in_a1, n) : d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a0   <= in_a0;
      out_a1   <= in_a1;
      out_b0   <= {in_b0[W-2:0], 1'b0};
      out_b1   <= {in_b1[W-2:0], 1'b0};
      out_r0   <= r0_next;
      out_r1   <= r1_next;
      out_side <= in_side;
    end
  end
endmodule

// File: tb/montgomery_xz_point_double_tb.sv
// Self-checking testbench for the Montgomery X:Z point doubling block.
module montgomery_xz_point_double_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mxzd_pkg::*;

  localparam int W = 64;
  localparam int LATENCY = 4 * W;
  localparam longint unsigned CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_MODULUS;
  logic [63:0] cfg_data = '0;

  montgomery_xz_point_double #(.WORD_BITS(W)) dut (.*);

  typedef struct packed {
    logic [63:0] qz;
    logic [63:0] qx;
  } point_t;

  // Predictor copy of the configuration.
  logic [63:0] cur_modulus;
  logic [63:0] cur_a24;
  point_t doubled_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  longint unsigned cycles = 0;

  initial forever #6 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p % 128'(n));
  endfunction

  // Expected doubled point for one input point.
  function automatic point_t double_point(logic [63:0] x0, logic [63:0] z0);
    point_t r;
    logic [63:0] n, a, u, v, w, t;
    logic [64:0] s;
    n = cur_modulus;
    if (n == 0) return '0;
    if (z0 == 0) begin
      r.qx = x0; r.qz = '0; return r;
    end
    x0 = x0 % n; z0 = z0 % n; a = cur_a24 % n;
    s = (65'(x0) + 65'(z0)) % 65'(n);
    u = mulmod(64'(s), 64'(s), n);
    v = (x0 >= z0) ? x0 - z0 : 64'((65'(x0) + 65'(n) - 65'(z0)));
    v = mulmod(v, v, n);
    w = (u >= v) ? u - v : 64'((65'(u) + 65'(n) - 65'(v)));
    s = (65'(mulmod(w, a, n)) + 65'(v)) % 65'(n);
    t = 64'(s);
    r.qx = mulmod(u, v, n);
    r.qz = mulmod(w, t, n);
    return r;
  endfunction

  // Receiver side: random stalls and result checking.
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    point_t got, exp_p;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (doubled_q.size() == 0) begin
        $error("unexpected result item %h", m_tdata);
        errors++;
      end else begin
        exp_p = doubled_q.pop_front();
        if (got.qx !== exp_p.qx) begin
          $error("qx expected %h actual %h", exp_p.qx, got.qx); errors++;
        end
        if (got.qz !== exp_p.qz) begin
          $error("qz expected %h actual %h", exp_p.qz, got.qz); errors++;
        end
      end
    end
  end

  // Send one point, idling beforehand at the current rate. The valid stays
  // high after the item is taken until the next item or an idle cycle.
  task automatic send_point(logic [63:0] x0, logic [63:0] z0);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {z0, x0};
    doubled_q.push_back(double_point(x0, z0));
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Wait until idle, then write a register.
  task automatic write_reg(logic idx, logic [63:0] val);
    s_tvalid <= 1'b0;
    while (doubled_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODULUS) cur_modulus = val; else cur_a24 = val;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_odd_mod();
    logic [63:0] m;
    case ($urandom_range(3))
      0: m = 64'($urandom_range(255));
      1: m = 64'($urandom());
      default: m = rand64();
    endcase
    return m | 64'd1;
  endfunction

  // Directed: field extremes, infinity, zero and even moduli, unreduced operands.
  task automatic test_directed();
    send_point(64'd2, 64'd1);
    send_point(64'd5, 64'd0);
    send_point('1, '1);
    write_reg(REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFC5);
    write_reg(REG_A24, '1);
    send_point('1, 64'd0);
    send_point(64'd0, '1);
    send_point('1, 64'hFFFF_FFFF_FFFF_FFC5);
    send_point(64'd12345, 64'd678);
    send_point(64'd0, 64'd1);
    write_reg(REG_MODULUS, 64'd0);
    send_point(64'd7, 64'd9);
    send_point(64'd7, 64'd0);
    write_reg(REG_MODULUS, 64'd1);
    send_point(64'd7, 64'd9);
    write_reg(REG_MODULUS, 64'd1000);
    write_reg(REG_A24, 64'd3);
    send_point(64'd999, 64'd1);
    send_point(64'd5, 64'd2000);
    write_reg(REG_MODULUS, 64'd3);
    write_reg(REG_A24, 64'd0);
    send_point(64'd1, 64'd1);
    send_point(64'd2, 64'd1);
  endtask

  // Random points over several curve settings at one idling profile.
  task automatic test_random(int s_idle, int r_idle, int count);
    logic [63:0] n, x0, z0;
    send_idle = s_idle; recv_idle = r_idle;
    for (int i = 0; i < count; i++) begin
      if (i % 70 == 0) begin
        write_reg(REG_MODULUS, rand_odd_mod());
        write_reg(REG_A24, ($urandom_range(5) == 0) ? rand64() : rand64() % cur_modulus);
      end
      n = cur_modulus;
      case ($urandom_range(9))
        0: begin x0 = rand64(); z0 = 64'd0; end
        1: begin x0 = rand64(); z0 = rand64(); end
        2: begin x0 = n - 1; z0 = n - 1; end
        default: begin x0 = rand64() % n; z0 = rand64() % n; end
      endcase
      send_point(x0, z0);
    end
  endtask

  initial begin
    cur_modulus = 64'd3;
    cur_a24 = 64'd0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    send_idle = 14; recv_idle = 50;
    test_directed();
    test_random(14, 50, 280);
    test_random(50, 14, 280);
    test_random(0, 0, 290);
    s_tvalid <= 1'b0;
    while (doubled_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/mxzd_pkg.sv
rtl/core/mxzd_red_cell.sv
rtl/core/mxzd_mul_cell.sv
rtl/core/montgomery_xz_point_double.sv
tb/montgomery_xz_point_double_tb.sv
